// ===== hw/rtl/pcsm_pkg.sv =====
package pcsm_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int PC_W        = 11;
  localparam int DATA_W      = 32;
  localparam int LVL_W       = 3;
  localparam int KIND_W      = 4;
  localparam int FAULT_W     = 2;
  localparam int EXT_W       = DATA_W + 2;
  localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

  // opcodes
  localparam logic [KIND_W-1:0] K_LIT = 4'd0;
  localparam logic [KIND_W-1:0] K_OPR = 4'd1;
  localparam logic [KIND_W-1:0] K_LOD = 4'd2;
  localparam logic [KIND_W-1:0] K_STO = 4'd3;
  localparam logic [KIND_W-1:0] K_CAL = 4'd4;
  localparam logic [KIND_W-1:0] K_INT = 4'd5;
  localparam logic [KIND_W-1:0] K_JMP = 4'd6;
  localparam logic [KIND_W-1:0] K_JPC = 4'd7;
  localparam logic [KIND_W-1:0] K_RED = 4'd8;
  localparam logic [KIND_W-1:0] K_WRT = 4'd9;

  // opr operation numbers
  localparam logic [DATA_W-1:0] OPR_RET = 32'd0;
  localparam logic [DATA_W-1:0] OPR_NEG = 32'd1;
  localparam logic [DATA_W-1:0] OPR_ADD = 32'd2;
  localparam logic [DATA_W-1:0] OPR_SUB = 32'd3;
  localparam logic [DATA_W-1:0] OPR_MUL = 32'd4;
  localparam logic [DATA_W-1:0] OPR_DIV = 32'd5;
  localparam logic [DATA_W-1:0] OPR_ODD = 32'd6;
  localparam logic [DATA_W-1:0] OPR_EQ  = 32'd8;
  localparam logic [DATA_W-1:0] OPR_NE  = 32'd9;
  localparam logic [DATA_W-1:0] OPR_LT  = 32'd10;
  localparam logic [DATA_W-1:0] OPR_GE  = 32'd11;
  localparam logic [DATA_W-1:0] OPR_GT  = 32'd12;
  localparam logic [DATA_W-1:0] OPR_LE  = 32'd13;

  // fault codes
  localparam logic [FAULT_W-1:0] F_NONE  = 2'd0;
  localparam logic [FAULT_W-1:0] F_EOF   = 2'd1;
  localparam logic [FAULT_W-1:0] F_RANGE = 2'd2;
  localparam logic [FAULT_W-1:0] F_DIV0  = 2'd3;

  typedef enum logic [1:0] {
    OC_NOP,
    OC_RET,
    OC_UN,
    OC_BIN
  } opr_cls_t;

  typedef enum logic [4:0] {
    U_NONE,
    U_CLEAR,
    U_LATCH,
    U_BAD,
    U_EOF,
    U_LIT,
    U_INT,
    U_JMP,
    U_RD_TOP,
    U_RD_TOPM1,
    U_CAP_X,
    U_RD_FB1,
    U_RD_FB2,
    U_CAP_Y,
    U_RET,
    U_UNARY,
    U_ALU,
    U_DIV_START,
    U_DIV_DONE,
    U_WR_R,
    U_WALK_RD,
    U_WALK_CAP,
    U_RD_ADDR,
    U_WR_LOD,
    U_WR_STO,
    U_CAL1,
    U_CAL2,
    U_CAL3,
    U_WR_RED,
    U_JPC,
    U_WRT,
    U_FIN
  } uop_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    opr_cls_t          opr_cls;
    logic              pre_ok;
    logic              eof;
    logic              walk_zero;
    logic              bb_ok;
    logic              addr_ok;
    logic              ret_ok;
    logic              y_zero;
    logic              is_div;
    logic              div_busy;
    logic              clr_last;
    logic              out_busy;
  } status_t;

endpackage

// ===== hw/rtl/pcsm_in_if.sv =====
interface pcsm_in_if;
  logic                            valid;
  logic                            ready;
  logic [pcsm_pkg::KIND_W-1:0]     kind;
  logic [pcsm_pkg::LVL_W-1:0]      level;
  logic signed [pcsm_pkg::DATA_W-1:0] operand;
  logic signed [pcsm_pkg::DATA_W-1:0] read_value;
  logic                            read_eof;

  modport source (output valid, kind, level, operand, read_value, read_eof, input ready);
  modport sink (input valid, kind, level, operand, read_value, read_eof, output ready);
endinterface

// ===== hw/rtl/pcsm_out_if.sv =====
interface pcsm_out_if;
  logic                               valid;
  logic                               ready;
  logic [pcsm_pkg::PC_W-1:0]          next_pc;
  logic                               write_valid;
  logic signed [pcsm_pkg::DATA_W-1:0] write_value;
  logic                               halted;
  logic [pcsm_pkg::FAULT_W-1:0]       fault;

  modport source (output valid, next_pc, write_valid, write_value, halted, fault, input ready);
  modport sink (input valid, next_pc, write_valid, write_value, halted, fault, output ready);
endinterface

// ===== hw/rtl/pcsm_div.sv =====
module pcsm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pcsm_pkg::DATA_W-1:0] dividend,
  input  logic [pcsm_pkg::DATA_W-1:0] divisor,
  output logic                        busy,
  output logic [pcsm_pkg::DATA_W-1:0] quotient
);

  logic                           busy_r, busy_nxt;
  logic [pcsm_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [pcsm_pkg::DATA_W-1:0]    rem_r, rem_nxt;
  logic [pcsm_pkg::DATA_W-1:0]    quo_r, quo_nxt;
  logic [pcsm_pkg::DATA_W-1:0]    den_r, den_nxt;
  logic                           neg_r, neg_nxt;
  logic [pcsm_pkg::DATA_W:0]      shifted;
  logic [pcsm_pkg::DATA_W:0]      trial;

  // one restoring step per cycle on magnitudes
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    shifted  = {rem_r, quo_r[pcsm_pkg::DATA_W-1]};
    trial    = shifted - {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = pcsm_pkg::DIV_CNT_W'(pcsm_pkg::DATA_W);
      rem_nxt  = '0;
      quo_nxt  = dividend[pcsm_pkg::DATA_W-1] ? -dividend : dividend;
      den_nxt  = divisor[pcsm_pkg::DATA_W-1] ? -divisor : divisor;
      neg_nxt  = dividend[pcsm_pkg::DATA_W-1] ^ divisor[pcsm_pkg::DATA_W-1];
    end else if (busy_r) begin
      if (!trial[pcsm_pkg::DATA_W]) begin
        rem_nxt = trial[pcsm_pkg::DATA_W-1:0];
        quo_nxt = {quo_r[pcsm_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[pcsm_pkg::DATA_W-1:0];
        quo_nxt = {quo_r[pcsm_pkg::DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == pcsm_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? -quo_r : quo_r;

endmodule

// ===== hw/rtl/pcsm_ctrl.sv =====
module pcsm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcsm_pkg::status_t st,
  output pcsm_pkg::uop_t    cmd
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_RET1,
    S_RET2,
    S_RET3,
    S_UN,
    S_BIN1,
    S_BIN2,
    S_BIN3,
    S_DIVW,
    S_BIN4,
    S_WALK,
    S_WCAP,
    S_LOD,
    S_STO,
    S_CAL2,
    S_CAL3,
    S_JPC,
    S_WRT,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // sequencing of micro-operations per instruction
  always_comb begin
    state_nxt = state_r;
    cmd       = pcsm_pkg::U_NONE;
    case (state_r)
      S_CLEAR: begin
        cmd = pcsm_pkg::U_CLEAR;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd       = pcsm_pkg::U_LATCH;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_FIN;
        if (st.kind == pcsm_pkg::K_RED && st.eof) begin
          cmd = pcsm_pkg::U_EOF;
        end else if (!st.pre_ok) begin
          cmd = pcsm_pkg::U_BAD;
        end else begin
          case (st.kind)
            pcsm_pkg::K_LIT: cmd = pcsm_pkg::U_LIT;
            pcsm_pkg::K_OPR: begin
              case (st.opr_cls)
                pcsm_pkg::OC_RET: begin
                  cmd       = pcsm_pkg::U_RD_FB1;
                  state_nxt = S_RET1;
                end
                pcsm_pkg::OC_UN: begin
                  cmd       = pcsm_pkg::U_RD_TOP;
                  state_nxt = S_UN;
                end
                pcsm_pkg::OC_BIN: begin
                  cmd       = pcsm_pkg::U_RD_TOP;
                  state_nxt = S_BIN1;
                end
                default: cmd = pcsm_pkg::U_NONE;
              endcase
            end
            pcsm_pkg::K_LOD, pcsm_pkg::K_STO, pcsm_pkg::K_CAL, pcsm_pkg::K_RED:
              state_nxt = S_WALK;
            pcsm_pkg::K_INT: cmd = pcsm_pkg::U_INT;
            pcsm_pkg::K_JMP: cmd = pcsm_pkg::U_JMP;
            pcsm_pkg::K_JPC: begin
              cmd       = pcsm_pkg::U_RD_TOP;
              state_nxt = S_JPC;
            end
            pcsm_pkg::K_WRT: begin
              cmd       = pcsm_pkg::U_RD_TOP;
              state_nxt = S_WRT;
            end
            default: cmd = pcsm_pkg::U_NONE;
          endcase
        end
      end
      S_RET1: begin
        cmd       = pcsm_pkg::U_RD_FB2;
        state_nxt = S_RET2;
      end
      S_RET2: begin
        cmd       = pcsm_pkg::U_CAP_Y;
        state_nxt = S_RET3;
      end
      S_RET3: begin
        cmd       = st.ret_ok ? pcsm_pkg::U_RET : pcsm_pkg::U_BAD;
        state_nxt = S_FIN;
      end
      S_UN: begin
        cmd       = pcsm_pkg::U_UNARY;
        state_nxt = S_FIN;
      end
      S_BIN1: begin
        cmd       = pcsm_pkg::U_RD_TOPM1;
        state_nxt = S_BIN2;
      end
      S_BIN2: begin
        cmd       = pcsm_pkg::U_CAP_X;
        state_nxt = S_BIN3;
      end
      S_BIN3: begin
        if (st.is_div && !st.y_zero) begin
          cmd       = pcsm_pkg::U_DIV_START;
          state_nxt = S_DIVW;
        end else begin
          cmd       = pcsm_pkg::U_ALU;
          state_nxt = S_BIN4;
        end
      end
      S_DIVW: begin
        if (!st.div_busy) begin
          cmd       = pcsm_pkg::U_DIV_DONE;
          state_nxt = S_BIN4;
        end
      end
      S_BIN4: begin
        cmd       = pcsm_pkg::U_WR_R;
        state_nxt = S_FIN;
      end
      // static-link chain walk shared by lod, sto, cal and red
      S_WALK: begin
        state_nxt = S_FIN;
        if (st.walk_zero) begin
          case (st.kind)
            pcsm_pkg::K_LOD: begin
              if (st.addr_ok) begin
                cmd       = pcsm_pkg::U_RD_ADDR;
                state_nxt = S_LOD;
              end else begin
                cmd = pcsm_pkg::U_BAD;
              end
            end
            pcsm_pkg::K_STO: begin
              if (st.addr_ok) begin
                cmd       = pcsm_pkg::U_RD_TOP;
                state_nxt = S_STO;
              end else begin
                cmd = pcsm_pkg::U_BAD;
              end
            end
            pcsm_pkg::K_CAL: begin
              cmd       = pcsm_pkg::U_CAL1;
              state_nxt = S_CAL2;
            end
            pcsm_pkg::K_RED: cmd = st.addr_ok ? pcsm_pkg::U_WR_RED : pcsm_pkg::U_BAD;
            default: cmd = pcsm_pkg::U_NONE;
          endcase
        end else if (!st.bb_ok) begin
          cmd = pcsm_pkg::U_BAD;
        end else begin
          cmd       = pcsm_pkg::U_WALK_RD;
          state_nxt = S_WCAP;
        end
      end
      S_WCAP: begin
        cmd       = pcsm_pkg::U_WALK_CAP;
        state_nxt = S_WALK;
      end
      S_LOD: begin
        cmd       = pcsm_pkg::U_WR_LOD;
        state_nxt = S_FIN;
      end
      S_STO: begin
        cmd       = pcsm_pkg::U_WR_STO;
        state_nxt = S_FIN;
      end
      S_CAL2: begin
        cmd       = pcsm_pkg::U_CAL2;
        state_nxt = S_CAL3;
      end
      S_CAL3: begin
        cmd       = pcsm_pkg::U_CAL3;
        state_nxt = S_FIN;
      end
      S_JPC: begin
        cmd       = pcsm_pkg::U_JPC;
        state_nxt = S_FIN;
      end
      S_WRT: begin
        cmd       = pcsm_pkg::U_WRT;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd       = pcsm_pkg::U_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ===== hw/rtl/pcsm_dp.sv =====
module pcsm_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pcsm_pkg::uop_t                     cmd,
  output pcsm_pkg::status_t                  st,
  input  logic [pcsm_pkg::KIND_W-1:0]        in_kind,
  input  logic [pcsm_pkg::LVL_W-1:0]         in_level,
  input  logic signed [pcsm_pkg::DATA_W-1:0] in_operand,
  input  logic signed [pcsm_pkg::DATA_W-1:0] in_read_value,
  input  logic                               in_read_eof,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pcsm_pkg::PC_W-1:0]          out_next_pc,
  output logic                               out_write_valid,
  output logic [pcsm_pkg::DATA_W-1:0]        out_write_value,
  output logic                               out_halted,
  output logic [pcsm_pkg::FAULT_W-1:0]       out_fault
);

  localparam int AW = pcsm_pkg::STACK_AW;
  localparam int DW = pcsm_pkg::DATA_W;
  localparam int XW = pcsm_pkg::EXT_W;
  localparam int PW = pcsm_pkg::PC_W;

  // stack memory, one write and one registered read per cycle
  logic [DW-1:0] mem [pcsm_pkg::STACK_DEPTH];
  logic [DW-1:0] rdata_r;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [DW-1:0] wr_data;

  // architectural state
  logic [AW-1:0] top_r, top_nxt;
  logic [AW-1:0] fb_r, fb_nxt;
  logic [PW-1:0] pc_r, pc_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  // per-item working registers
  logic [pcsm_pkg::KIND_W-1:0]  kind_r, kind_nxt;
  logic [pcsm_pkg::LVL_W-1:0]   cnt_r, cnt_nxt;
  logic [DW-1:0]                op_r, op_nxt;
  logic [DW-1:0]                rv_r, rv_nxt;
  logic                         eof_r, eof_nxt;
  logic [DW-1:0]                bb_r, bb_nxt;
  logic [DW-1:0]                x_r, x_nxt;
  logic [DW-1:0]                y_r, y_nxt;
  logic [DW-1:0]                res_r, res_nxt;
  logic [AW-1:0]                nt_r, nt_nxt;
  logic [AW-1:0]                nbp_r, nbp_nxt;
  logic [PW-1:0]                npc_r, npc_nxt;
  logic                         bad_r, bad_nxt;
  logic                         eofm_r, eofm_nxt;
  logic                         wv_r, wv_nxt;
  logic [DW-1:0]                wval_r, wval_nxt;
  logic [pcsm_pkg::FAULT_W-1:0] fault_r, fault_nxt;

  // result register
  logic                         ov_r, ov_nxt;
  logic [PW-1:0]                onpc_r, onpc_nxt;
  logic                         owv_r, owv_nxt;
  logic [DW-1:0]                owval_r, owval_nxt;
  logic                         ohalt_r, ohalt_nxt;
  logic [pcsm_pkg::FAULT_W-1:0] ofault_r, ofault_nxt;

  // range checks
  logic signed [XW-1:0] op_s, top_s, bb_s, int_sum, addr_s, x_s;
  logic                 pre_ok, int_ok;
  pcsm_pkg::opr_cls_t   cls;
  logic [2*DW-1:0]      prod;
  logic [DW-1:0]        alu;
  logic [DW-1:0]        odd_val;
  logic                 div_busy;
  logic [DW-1:0]        div_q;

  assign op_s    = XW'($signed(op_r));
  assign top_s   = $signed(XW'(top_r));
  assign bb_s    = XW'($signed(bb_r));
  assign x_s     = XW'($signed(x_r));
  assign int_sum = top_s + op_s;
  assign addr_s  = bb_s + op_s;
  assign int_ok  = (int_sum >= 0) && (int_sum < pcsm_pkg::STACK_DEPTH);

  // opr classification
  always_comb begin
    if (op_r == pcsm_pkg::OPR_RET) begin
      cls = pcsm_pkg::OC_RET;
    end else if (op_r == pcsm_pkg::OPR_NEG || op_r == pcsm_pkg::OPR_ODD) begin
      cls = pcsm_pkg::OC_UN;
    end else if (op_r == pcsm_pkg::OPR_ADD || op_r == pcsm_pkg::OPR_SUB ||
                 op_r == pcsm_pkg::OPR_MUL || op_r == pcsm_pkg::OPR_DIV ||
                 op_r == pcsm_pkg::OPR_EQ  || op_r == pcsm_pkg::OPR_NE  ||
                 op_r == pcsm_pkg::OPR_LT  || op_r == pcsm_pkg::OPR_GE  ||
                 op_r == pcsm_pkg::OPR_GT  || op_r == pcsm_pkg::OPR_LE) begin
      cls = pcsm_pkg::OC_BIN;
    end else begin
      cls = pcsm_pkg::OC_NOP;
    end
  end

  // checks that need only the item and the pointers
  always_comb begin
    case (kind_r)
      pcsm_pkg::K_LIT, pcsm_pkg::K_LOD:
        pre_ok = (top_r != AW'(pcsm_pkg::STACK_DEPTH - 1));
      pcsm_pkg::K_OPR: begin
        case (cls)
          pcsm_pkg::OC_RET:
            pre_ok = (fb_r != '0) && (fb_r <= AW'(pcsm_pkg::STACK_DEPTH - 3));
          pcsm_pkg::OC_BIN: pre_ok = (top_r != '0);
          default:          pre_ok = 1'b1;
        endcase
      end
      pcsm_pkg::K_STO, pcsm_pkg::K_JPC, pcsm_pkg::K_WRT:
        pre_ok = (top_r != '0);
      pcsm_pkg::K_CAL: pre_ok = (top_r <= AW'(pcsm_pkg::STACK_DEPTH - 4));
      pcsm_pkg::K_INT: pre_ok = int_ok;
      default:         pre_ok = 1'b1;
    endcase
  end

  always_comb begin
    st.kind      = kind_r;
    st.opr_cls   = cls;
    st.pre_ok    = pre_ok;
    st.eof       = eof_r;
    st.walk_zero = (cnt_r == '0);
    st.bb_ok     = (bb_s >= 0) && (bb_s < pcsm_pkg::STACK_DEPTH);
    st.addr_ok   = (addr_s >= 0) && (addr_s < pcsm_pkg::STACK_DEPTH);
    st.ret_ok    = (x_s >= 0) && (x_s < pcsm_pkg::STACK_DEPTH);
    st.y_zero    = (y_r == '0);
    st.is_div    = (op_r == pcsm_pkg::OPR_DIV);
    st.div_busy  = div_busy;
    st.clr_last  = (clr_r == AW'(pcsm_pkg::STACK_DEPTH - 1));
    st.out_busy  = ov_r && !out_ready;
  end

  // binary alu, divide by zero gives zero
  assign prod = x_r * y_r;
  always_comb begin
    case (op_r)
      pcsm_pkg::OPR_ADD: alu = x_r + y_r;
      pcsm_pkg::OPR_SUB: alu = x_r - y_r;
      pcsm_pkg::OPR_MUL: alu = prod[DW-1:0];
      pcsm_pkg::OPR_EQ:  alu = DW'(x_r == y_r);
      pcsm_pkg::OPR_NE:  alu = DW'(x_r != y_r);
      pcsm_pkg::OPR_LT:  alu = DW'($signed(x_r) < $signed(y_r));
      pcsm_pkg::OPR_GE:  alu = DW'($signed(x_r) >= $signed(y_r));
      pcsm_pkg::OPR_GT:  alu = DW'($signed(x_r) > $signed(y_r));
      pcsm_pkg::OPR_LE:  alu = DW'($signed(x_r) <= $signed(y_r));
      default:           alu = '0;
    endcase
  end

  // truncating remainder by two
  assign odd_val = !rdata_r[0] ? '0 : (rdata_r[DW-1] ? '1 : DW'(1));

  pcsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd == pcsm_pkg::U_DIV_START),
    .dividend (x_r),
    .divisor  (y_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // micro-operation decode
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = top_r;
    wr_data   = '0;
    rd_en     = 1'b0;
    rd_addr   = top_r;
    top_nxt   = top_r;
    fb_nxt    = fb_r;
    pc_nxt    = pc_r;
    clr_nxt   = clr_r;
    kind_nxt  = kind_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    rv_nxt    = rv_r;
    eof_nxt   = eof_r;
    bb_nxt    = bb_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    res_nxt   = res_r;
    nt_nxt    = nt_r;
    nbp_nxt   = nbp_r;
    npc_nxt   = npc_r;
    bad_nxt   = bad_r;
    eofm_nxt  = eofm_r;
    wv_nxt    = wv_r;
    wval_nxt  = wval_r;
    fault_nxt = fault_r;
    ov_nxt    = ov_r && !out_ready;
    onpc_nxt  = onpc_r;
    owv_nxt   = owv_r;
    owval_nxt = owval_r;
    ohalt_nxt = ohalt_r;
    ofault_nxt = ofault_r;
    case (cmd)
      pcsm_pkg::U_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
      end
      pcsm_pkg::U_LATCH: begin
        kind_nxt  = in_kind;
        cnt_nxt   = in_level;
        op_nxt    = in_operand;
        rv_nxt    = in_read_value;
        eof_nxt   = in_read_eof;
        bb_nxt    = DW'(fb_r);
        nt_nxt    = top_r;
        nbp_nxt   = fb_r;
        npc_nxt   = pc_r + 1'b1;
        bad_nxt   = 1'b0;
        eofm_nxt  = 1'b0;
        wv_nxt    = 1'b0;
        wval_nxt  = '0;
        fault_nxt = pcsm_pkg::F_NONE;
      end
      pcsm_pkg::U_BAD: bad_nxt = 1'b1;
      pcsm_pkg::U_EOF: eofm_nxt = 1'b1;
      pcsm_pkg::U_LIT: begin
        wr_en   = 1'b1;
        wr_addr = top_r + 1'b1;
        wr_data = op_r;
        nt_nxt  = top_r + 1'b1;
      end
      pcsm_pkg::U_INT: nt_nxt = int_sum[AW-1:0];
      pcsm_pkg::U_JMP: npc_nxt = op_r[PW-1:0];
      pcsm_pkg::U_RD_TOP: begin
        rd_en   = 1'b1;
        rd_addr = top_r;
      end
      pcsm_pkg::U_RD_TOPM1: begin
        y_nxt   = rdata_r;
        rd_en   = 1'b1;
        rd_addr = top_r - 1'b1;
      end
      pcsm_pkg::U_CAP_X: x_nxt = rdata_r;
      pcsm_pkg::U_RD_FB1: begin
        rd_en   = 1'b1;
        rd_addr = fb_r + AW'(1);
      end
      pcsm_pkg::U_RD_FB2: begin
        x_nxt   = rdata_r;
        rd_en   = 1'b1;
        rd_addr = fb_r + AW'(2);
      end
      pcsm_pkg::U_CAP_Y: y_nxt = rdata_r;
      pcsm_pkg::U_RET: begin
        nt_nxt  = fb_r - 1'b1;
        nbp_nxt = x_r[AW-1:0];
        npc_nxt = y_r[PW-1:0];
      end
      pcsm_pkg::U_UNARY: begin
        wr_en   = 1'b1;
        wr_addr = top_r;
        wr_data = (op_r == pcsm_pkg::OPR_NEG) ? -rdata_r : odd_val;
      end
      pcsm_pkg::U_ALU: begin
        res_nxt = alu;
        if (op_r == pcsm_pkg::OPR_DIV) fault_nxt = pcsm_pkg::F_DIV0;
      end
      pcsm_pkg::U_DIV_DONE: res_nxt = div_q;
      pcsm_pkg::U_WR_R: begin
        wr_en   = 1'b1;
        wr_addr = top_r - 1'b1;
        wr_data = res_r;
        nt_nxt  = top_r - 1'b1;
      end
      pcsm_pkg::U_WALK_RD: begin
        rd_en   = 1'b1;
        rd_addr = bb_r[AW-1:0];
        cnt_nxt = cnt_r - 1'b1;
      end
      pcsm_pkg::U_WALK_CAP: bb_nxt = rdata_r;
      pcsm_pkg::U_RD_ADDR: begin
        rd_en   = 1'b1;
        rd_addr = addr_s[AW-1:0];
      end
      pcsm_pkg::U_WR_LOD: begin
        wr_en   = 1'b1;
        wr_addr = top_r + 1'b1;
        wr_data = rdata_r;
        nt_nxt  = top_r + 1'b1;
      end
      pcsm_pkg::U_WR_STO: begin
        wr_en   = 1'b1;
        wr_addr = addr_s[AW-1:0];
        wr_data = rdata_r;
        nt_nxt  = top_r - 1'b1;
      end
      pcsm_pkg::U_CAL1: begin
        wr_en   = 1'b1;
        wr_addr = top_r + AW'(1);
        wr_data = bb_r;
      end
      pcsm_pkg::U_CAL2: begin
        wr_en   = 1'b1;
        wr_addr = top_r + AW'(2);
        wr_data = DW'(fb_r);
      end
      pcsm_pkg::U_CAL3: begin
        wr_en   = 1'b1;
        wr_addr = top_r + AW'(3);
        wr_data = DW'(npc_r);
        nbp_nxt = top_r + AW'(1);
        npc_nxt = op_r[PW-1:0];
      end
      pcsm_pkg::U_WR_RED: begin
        wr_en   = 1'b1;
        wr_addr = addr_s[AW-1:0];
        wr_data = rv_r;
      end
      pcsm_pkg::U_JPC: begin
        if (rdata_r == '0) npc_nxt = op_r[PW-1:0];
        nt_nxt = top_r - 1'b1;
      end
      pcsm_pkg::U_WRT: begin
        wv_nxt   = 1'b1;
        wval_nxt = rdata_r;
        nt_nxt   = top_r - 1'b1;
      end
      // load the result register, and commit state unless the item was rejected or hit eof
      pcsm_pkg::U_FIN: begin
        ov_nxt = 1'b1;
        if (bad_r) begin
          onpc_nxt   = pc_r;
          owv_nxt    = 1'b0;
          owval_nxt  = '0;
          ohalt_nxt  = 1'b0;
          ofault_nxt = pcsm_pkg::F_RANGE;
        end else if (eofm_r) begin
          onpc_nxt   = pc_r;
          owv_nxt    = 1'b0;
          owval_nxt  = '0;
          ohalt_nxt  = 1'b1;
          ofault_nxt = pcsm_pkg::F_EOF;
        end else begin
          top_nxt    = nt_r;
          fb_nxt     = nbp_r;
          pc_nxt     = npc_r;
          onpc_nxt   = npc_r;
          owv_nxt    = wv_r;
          owval_nxt  = wval_r;
          ohalt_nxt  = (npc_r == '0);
          ofault_nxt = fault_r;
        end
      end
      default: ;
    endcase
  end

  // stack memory port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
      fb_r  <= AW'(1);
      pc_r  <= '0;
      clr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      top_r <= top_nxt;
      fb_r  <= fb_nxt;
      pc_r  <= pc_nxt;
      clr_r <= clr_nxt;
      ov_r  <= ov_nxt;
    end
    kind_r   <= kind_nxt;
    cnt_r    <= cnt_nxt;
    op_r     <= op_nxt;
    rv_r     <= rv_nxt;
    eof_r    <= eof_nxt;
    bb_r     <= bb_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    res_r    <= res_nxt;
    nt_r     <= nt_nxt;
    nbp_r    <= nbp_nxt;
    npc_r    <= npc_nxt;
    bad_r    <= bad_nxt;
    eofm_r   <= eofm_nxt;
    wv_r     <= wv_nxt;
    wval_r   <= wval_nxt;
    fault_r  <= fault_nxt;
    onpc_r   <= onpc_nxt;
    owv_r    <= owv_nxt;
    owval_r  <= owval_nxt;
    ohalt_r  <= ohalt_nxt;
    ofault_r <= ofault_nxt;
  end

  assign out_valid       = ov_r;
  assign out_next_pc     = onpc_r;
  assign out_write_valid = owv_r;
  assign out_write_value = owval_r;
  assign out_halted      = ohalt_r;
  assign out_fault       = ofault_r;

endmodule

// ===== hw/rtl/pcode_stack_machine_step.sv =====
// sequence: lit, jmp, int, no-ops and items rejected at decode pass from decode
//   straight to finish; stack ops add read and write states, each static-link level
//   walked adds a read and a capture state, and opr div with a nonzero divisor
//   waits on the divider (1 quotient bit a cycle)
// throughput: one instruction at a time; the next item is taken while a result waits
// reset: synchronous active-low; a clearing pass zeroes all 1024 stack entries
module pcode_stack_machine_step (
  input  logic              clk,
  input  logic              rst_n,
  pcsm_in_if.sink           in_ch,
  pcsm_out_if.source        out_ch
);

  pcsm_pkg::status_t st;
  pcsm_pkg::uop_t    cmd;
  logic              in_ready;

  pcsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  pcsm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_kind         (in_ch.kind),
    .in_level        (in_ch.level),
    .in_operand      (in_ch.operand),
    .in_read_value   (in_ch.read_value),
    .in_read_eof     (in_ch.read_eof),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_next_pc     (out_ch.next_pc),
    .out_write_valid (out_ch.write_valid),
    .out_write_value (out_ch.write_value),
    .out_halted      (out_ch.halted),
    .out_fault       (out_ch.fault)
  );

  assign in_ch.ready = in_ready;

endmodule

// ===== verif/pcsm_tb_pkg.sv =====
`timescale 1ns / 100ps
package pcsm_tb_pkg;
  import pcsm_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [LVL_W-1:0]         level;
    logic signed [DATA_W-1:0] operand;
    logic signed [DATA_W-1:0] read_value;
    logic                     read_eof;
  } instr_t;

  typedef struct packed {
    logic [PC_W-1:0]          next_pc;
    logic                     write_valid;
    logic signed [DATA_W-1:0] write_value;
    logic                     halted;
    logic [FAULT_W-1:0]       fault;
  } step_res_t;
endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import pcsm_pkg::*;
  import pcsm_tb_pkg::*;

  localparam int CODE_DEPTH  = 2048;
  localparam int WDOG_LIMIT  = 20000;
  localparam int NUM_RANDOM  = 1530;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pcsm_in_if  in_ch();
  pcsm_out_if out_ch();

  pcode_stack_machine_step u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #4 clk = ~clk;

  // machine state mirror
  logic [DATA_W-1:0] mem_m [STACK_DEPTH];
  int                top_m;
  int                fb_m;
  int                pc_m;

  instr_t    pending_q[$];
  step_res_t expect_q[$];
  int        mismatch_cnt = 0;
  bit        stim_done = 1'b0;
  int        idle_cycles = 0;

  function automatic bit in_stack(longint x);
    return x >= 0 && x < STACK_DEPTH;
  endfunction

  function automatic logic [DATA_W-1:0] tdiv(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                             bit rem);
    longint sa, sb;
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    return rem ? DATA_W'(sa % sb) : DATA_W'(sa / sb);
  endfunction

  // follow static links, returns 0 if a link is out of range
  function automatic bit chain_walk(int lvl, output longint bb);
    bb = fb_m;
    for (int i = 0; i < lvl; i++) begin
      if (!in_stack(bb)) return 1'b0;
      bb = longint'($signed(mem_m[bb]));
    end
    return 1'b1;
  endfunction

  // execute one instruction on the mirror and return its result
  function automatic step_res_t exec_instr(instr_t it);
    step_res_t r;
    longint t, nt, bb, addr, nb, op;
    int npc, nbp;
    logic [DATA_W-1:0] x, y, v;
    bit bad;
    t = top_m;
    nt = t;
    npc = (pc_m + 1) % CODE_DEPTH;
    nbp = fb_m;
    op = longint'(it.operand);
    bad = 1'b0;
    r = '0;
    case (it.kind)
      K_LIT: begin
        nt = t + 1;
        if (!in_stack(nt)) bad = 1'b1;
        else mem_m[nt] = it.operand;
      end
      K_OPR: begin
        if (it.operand == OPR_RET) begin
          nt = fb_m - 1;
          if (!in_stack(nt) || !in_stack(nt + 3)) bad = 1'b1;
          else begin
            nb = longint'($signed(mem_m[nt + 2]));
            if (!in_stack(nb)) bad = 1'b1;
            else begin
              nbp = int'(nb);
              npc = int'(mem_m[nt + 3] % CODE_DEPTH);
            end
          end
        end else if (it.operand == OPR_NEG) begin
          mem_m[t] = -mem_m[t];
        end else if (it.operand == OPR_ODD) begin
          mem_m[t] = tdiv(mem_m[t], 2, 1'b1);
        end else if ((op >= 2 && op <= 5) || (op >= 8 && op <= 13)) begin
          if (t < 1) bad = 1'b1;
          else begin
            nt = t - 1;
            x = mem_m[nt];
            y = mem_m[t];
            case (it.operand)
              OPR_ADD: v = x + y;
              OPR_SUB: v = x - y;
              OPR_MUL: v = x * y;
              OPR_DIV: begin
                if (y == 0) begin
                  v = '0;
                  r.fault = F_DIV0;
                end else v = tdiv(x, y, 1'b0);
              end
              OPR_EQ: v = DATA_W'(x == y);
              OPR_NE: v = DATA_W'(x != y);
              OPR_LT: v = DATA_W'($signed(x) < $signed(y));
              OPR_GE: v = DATA_W'($signed(x) >= $signed(y));
              OPR_GT: v = DATA_W'($signed(x) > $signed(y));
              default: v = DATA_W'($signed(x) <= $signed(y));
            endcase
            mem_m[nt] = v;
          end
        end
      end
      K_LOD: begin
        nt = t + 1;
        if (!in_stack(nt) || !chain_walk(it.level, bb)) bad = 1'b1;
        else begin
          addr = bb + op;
          if (!in_stack(addr)) bad = 1'b1;
          else mem_m[nt] = mem_m[addr];
        end
      end
      K_STO: begin
        if (t < 1 || !chain_walk(it.level, bb)) bad = 1'b1;
        else begin
          addr = bb + op;
          if (!in_stack(addr)) bad = 1'b1;
          else begin
            mem_m[addr] = mem_m[t];
            nt = t - 1;
          end
        end
      end
      K_CAL: begin
        if (!in_stack(t + 3) || !chain_walk(it.level, bb)) bad = 1'b1;
        else begin
          mem_m[t + 1] = DATA_W'(bb);
          mem_m[t + 2] = DATA_W'(fb_m);
          mem_m[t + 3] = DATA_W'(npc);
          nbp = int'(t + 1);
          npc = int'(it.operand[PC_W-1:0]);
        end
      end
      K_INT: begin
        nt = t + op;
        if (!in_stack(nt)) bad = 1'b1;
      end
      K_JMP: npc = int'(it.operand[PC_W-1:0]);
      K_JPC: begin
        if (t < 1) bad = 1'b1;
        else begin
          if (mem_m[t] == 0) npc = int'(it.operand[PC_W-1:0]);
          nt = t - 1;
        end
      end
      K_RED: begin
        if (it.read_eof) begin
          r.next_pc = PC_W'(pc_m);
          r.halted = 1'b1;
          r.fault = F_EOF;
          return r;
        end
        if (!chain_walk(it.level, bb)) bad = 1'b1;
        else begin
          addr = bb + op;
          if (!in_stack(addr)) bad = 1'b1;
          else mem_m[addr] = it.read_value;
        end
      end
      K_WRT: begin
        if (t < 1) bad = 1'b1;
        else begin
          r.write_valid = 1'b1;
          r.write_value = mem_m[t];
          nt = t - 1;
        end
      end
      default: ;
    endcase
    if (bad) begin
      r = '0;
      r.next_pc = PC_W'(pc_m);
      r.fault = F_RANGE;
      return r;
    end
    top_m = int'(nt);
    fb_m = nbp;
    pc_m = npc;
    r.next_pc = PC_W'(npc);
    r.halted = (npc == 0);
    return r;
  endfunction

  function automatic instr_t mk(logic [KIND_W-1:0] k, int lvl, int opnd);
    instr_t it;
    it.kind = k;
    it.level = LVL_W'(lvl);
    it.operand = opnd;
    it.read_value = $urandom;
    it.read_eof = 1'b0;
    return it;
  endfunction

  function automatic int rand_small();
    return $urandom_range(0, 3) == 0 ? int'($urandom) : $urandom_range(0, 40) - 20;
  endfunction

  // mostly well-formed programs: lit, opr, lod, sto, cal, int, jmp, jpc, red and wrt
  function automatic instr_t rand_instr();
    instr_t it;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 22) it = mk(K_LIT, 0, rand_small());
    else if (sel < 42) begin
      it = mk(K_OPR, 0, $urandom_range(0, 13));
      if ($urandom_range(0, 9) == 0) it.operand = $urandom;
    end else if (sel < 52) it = mk(K_LOD, $urandom_range(0, 3), $urandom_range(0, 8) - 1);
    else if (sel < 60) it = mk(K_STO, $urandom_range(0, 3), $urandom_range(0, 8) - 1);
    else if (sel < 66) it = mk(K_CAL, $urandom_range(0, 2), $urandom);
    else if (sel < 72) it = mk(K_INT, 0, $urandom_range(0, 9) == 0 ? int'($urandom)
                                               : $urandom_range(0, 10) - 3);
    else if (sel < 76) it = mk(K_JMP, 0, $urandom);
    else if (sel < 82) it = mk(K_JPC, 0, $urandom);
    else if (sel < 88) begin
      it = mk(K_RED, $urandom_range(0, 2), $urandom_range(0, 8) - 1);
      it.read_eof = ($urandom_range(0, 7) == 0);
    end else if (sel < 96) it = mk(K_WRT, 0, 0);
    else begin
      it = mk(KIND_W'($urandom_range(10, 15)), $urandom_range(0, 7), $urandom);
      it.read_eof = 1'($urandom_range(0, 1));
    end
    if ($urandom_range(0, 15) == 0) it.level = LVL_W'($urandom_range(0, 7));
    return it;
  endfunction

  // stimulus
  initial begin
    pending_q.push_back(mk(K_WRT, 0, 0));
    pending_q.push_back(mk(K_LIT, 0, 32'h7fffffff));
    pending_q.push_back(mk(K_LIT, 0, 32'h80000000));
    pending_q.push_back(mk(K_OPR, 0, OPR_ADD));
    pending_q.push_back(mk(K_LIT, 0, -7));
    pending_q.push_back(mk(K_LIT, 0, 0));
    pending_q.push_back(mk(K_OPR, 0, OPR_DIV));
    pending_q.push_back(mk(K_LIT, 0, -7));
    pending_q.push_back(mk(K_OPR, 0, OPR_ODD));
    pending_q.push_back(mk(K_LIT, 0, 2));
    pending_q.push_back(mk(K_OPR, 0, OPR_DIV));
    pending_q.push_back(mk(K_OPR, 0, OPR_NEG));
    pending_q.push_back(mk(K_LIT, 0, 3));
    pending_q.push_back(mk(K_OPR, 0, OPR_LE));
    pending_q.push_back(mk(K_INT, 0, 2000));
    pending_q.push_back(mk(K_INT, 0, 1023));
    pending_q.push_back(mk(K_INT, 0, -1020));
    pending_q.push_back(mk(K_LOD, 7, 2));
    pending_q.push_back(mk(K_CAL, 1, 32'hffffffff));
    pending_q.push_back(mk(K_STO, 0, 0));
    pending_q.push_back(mk(K_OPR, 0, OPR_RET));
    pending_q.push_back(mk(K_JMP, 0, 2048));
    begin
      instr_t it;
      it = mk(K_RED, 0, 3);
      it.read_eof = 1'b1;
      pending_q.push_back(it);
      it = mk(K_RED, 0, 0);
      it.read_value = 32'h80000000;
      pending_q.push_back(it);
    end
    pending_q.push_back(mk(K_JPC, 0, 5));
    pending_q.push_back(mk(4'hf, 7, -1));
    for (int i = 0; i < NUM_RANDOM; i++) pending_q.push_back(rand_instr());
  end

  // reset and mirror init
  initial begin
    for (int i = 0; i < STACK_DEPTH; i++) mem_m[i] = '0;
    top_m = 0;
    fb_m = 1;
    pc_m = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver with bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.kind <= '0;
      in_ch.level <= '0;
      in_ch.operand <= '0;
      in_ch.read_value <= '0;
      in_ch.read_eof <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        void'(pending_q.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() > (in_ch.valid && in_ch.ready ? 0 : 0) &&
                     pending_q.size() != 0) begin
          in_ch.valid <= 1'b1;
          {in_ch.kind, in_ch.level, in_ch.operand, in_ch.read_value, in_ch.read_eof}
            <= pending_q[0];
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // predict on acceptance
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expect_q.push_back(exec_instr({in_ch.kind, in_ch.level, in_ch.operand,
                                     in_ch.read_value, in_ch.read_eof}));
    end
  end

  // receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9]) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor and compare
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      step_res_t got, exp_r;
      got = {out_ch.next_pc, out_ch.write_valid, out_ch.write_value, out_ch.halted,
             out_ch.fault};
      if (expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result item %p", got);
      end else begin
        exp_r = expect_q.pop_front();
        if (got.next_pc !== exp_r.next_pc || got.write_valid !== exp_r.write_valid ||
            got.write_value !== exp_r.write_value || got.halted !== exp_r.halted ||
            got.fault !== exp_r.fault) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (expect_q.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatch_cnt == 0 && expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
